>>> sv/isps_pkg.sv
// ---------------------------------------------------------------------------
// isps_pkg
// Shared constants and controller/datapath interface types for the
// inverse-square pair sum block.
// ---------------------------------------------------------------------------
package isps_pkg;

    localparam int MAX_POINTS = 256;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int PT_W       = 16;
    localparam int ACC_W      = 64;
    localparam int SQ_W       = 2 * PT_W;
    // quotient of 2^(3*PT_W) by a nonzero square needs 3*PT_W+1 bits
    localparam int Q_W        = 3 * PT_W + 1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic             load;
        logic             take_query;
        logic             issue;
        logic [IDX_W-1:0] issue_idx;
        logic             finish;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             busy;
        logic             out_full;
    } t_status;

endpackage

>>> sv/isps_div.sv
// ---------------------------------------------------------------------------
// isps_div
// Pipelined restoring divider: 2^(3*PT_W) / divisor, one quotient bit per
// stage, one new divisor accepted every cycle; a skipped divisor gives zero.
// ---------------------------------------------------------------------------
module isps_div
    import isps_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_skip,
    input  logic [SQ_W-1:0] i_divisor,
    output logic            o_valid,
    output logic [Q_W-1:0]  o_term,
    output logic            o_busy
);

    logic [Q_W-1:0]  r_vld;
    logic [Q_W-1:0]  r_skip;
    logic [SQ_W-1:0] r_rem [Q_W];
    logic [SQ_W-1:0] r_div [Q_W];
    logic [Q_W-1:0]  r_q   [Q_W];

    genvar g;
    generate
        for (g = 0; g < Q_W; g++) begin : g_stage
            logic [SQ_W-1:0] prev_rem;
            logic [SQ_W-1:0] prev_div;
            logic [Q_W-1:0]  prev_q;
            logic            prev_vld;
            logic            prev_skip;
            logic [SQ_W:0]   trial;
            logic            ge;
            logic [SQ_W-1:0] n_rem;

            if (g == 0) begin : g_first
                assign prev_rem  = '0;
                assign prev_div  = i_divisor;
                assign prev_q    = '0;
                assign prev_vld  = i_valid;
                assign prev_skip = i_skip;
            end else begin : g_rest
                assign prev_rem  = r_rem[g-1];
                assign prev_div  = r_div[g-1];
                assign prev_q    = r_q[g-1];
                assign prev_vld  = r_vld[g-1];
                assign prev_skip = r_skip[g-1];
            end

            // dividend is a single one at its top bit
            always_comb begin
                trial = {prev_rem, (g == 0) ? 1'b1 : 1'b0};
                ge    = (trial >= {1'b0, prev_div});
                n_rem = ge ? SQ_W'(trial - {1'b0, prev_div}) : trial[SQ_W-1:0];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else begin
                    r_vld[g] <= prev_vld;
                end
                r_skip[g] <= prev_skip;
                r_rem[g]  <= n_rem;
                r_div[g]  <= prev_div;
                r_q[g]    <= {prev_q[Q_W-2:0], ge};
            end
        end
    endgenerate

    assign o_valid = r_vld[Q_W-1];
    assign o_term  = r_skip[Q_W-1] ? '0 : r_q[Q_W-1];
    assign o_busy  = |r_vld;

endmodule

>>> sv/isps_dp.sv
// ---------------------------------------------------------------------------
// isps_dp
// Datapath: point table, difference and square stages, divider, saturating
// accumulator and the result register.
// ---------------------------------------------------------------------------
module isps_dp
    import isps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    input  logic [PT_W-1:0]  i_point,
    input  logic             i_first_item,
    input  logic             i_last_item,
    input  logic [ACC_W-1:0] i_acc_in,
    output logic             o_valid,
    input  logic             o_ready,
    output logic [ACC_W-1:0] o_result_sum,
    output logic             o_saturated,
    output logic             o_run_done
);

    logic [PT_W-1:0]  r_mem [MAX_POINTS];
    logic [CNT_W-1:0] r_count;

    logic [PT_W-1:0]  r_x;
    logic [ACC_W-1:0] r_acc;
    logic             r_last;

    logic             r_rd_vld;
    logic [PT_W-1:0]  r_rd_pt;
    logic             r_df_vld;
    logic [PT_W-1:0]  r_df;
    logic             r_sq_vld;
    logic             r_sq_skip;
    logic [SQ_W-1:0]  r_sq;

    logic             div_vld;
    logic [Q_W-1:0]   div_term;
    logic             div_busy;

    logic [ACC_W-1:0] r_sum;
    logic             r_clip;
    logic [ACC_W:0]   pair_add;
    logic [ACC_W:0]   final_add;

    logic             r_out_vld;
    logic [ACC_W-1:0] r_out_sum;
    logic             r_out_sat;
    logic             r_out_done;

    logic             full;
    logic [IDX_W-1:0] wr_addr;

    assign full    = (r_count >= CNT_W'(MAX_POINTS));
    assign wr_addr = i_first_item ? '0 : r_count[IDX_W-1:0];

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (i_first_item || !full)) begin
            r_mem[wr_addr] <= i_point;
        end
        r_rd_pt <= r_mem[i_cmd.issue_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            if (i_first_item) begin
                r_count <= CNT_W'(1);
            end else if (!full) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_query) begin
            r_x    <= i_point;
            r_acc  <= i_acc_in;
            r_last <= i_last_item;
        end
    end

    // difference, then square
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_df_vld <= 1'b0;
            r_sq_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            r_df_vld <= r_rd_vld;
            r_sq_vld <= r_df_vld;
        end
        r_df      <= (r_x >= r_rd_pt) ? (r_x - r_rd_pt) : (r_rd_pt - r_x);
        r_sq      <= SQ_W'(r_df) * SQ_W'(r_df);
        r_sq_skip <= (r_df == '0);
    end

    isps_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_sq_vld),
        .i_skip    (r_sq_skip),
        .i_divisor (r_sq),
        .o_valid   (div_vld),
        .o_term    (div_term),
        .o_busy    (div_busy)
    );

    assign pair_add  = {1'b0, r_sum} + (ACC_W + 1)'(div_term);
    assign final_add = {1'b0, r_acc} + {1'b0, r_sum};

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_query) begin
            r_sum  <= '0;
            r_clip <= 1'b0;
        end else if (div_vld) begin
            r_sum  <= pair_add[ACC_W] ? '1 : pair_add[ACC_W-1:0];
            r_clip <= r_clip | pair_add[ACC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (o_ready) begin
            r_out_vld <= 1'b0;
        end
        if (i_cmd.finish) begin
            r_out_sum  <= final_add[ACC_W] ? '1 : final_add[ACC_W-1:0];
            r_out_sat  <= r_clip | final_add[ACC_W];
            r_out_done <= r_last;
        end
    end

    assign o_status.count    = r_count;
    assign o_status.busy     = r_rd_vld | r_df_vld | r_sq_vld | div_busy;
    assign o_status.out_full = r_out_vld;

    assign o_valid      = r_out_vld;
    assign o_result_sum = r_out_sum;
    assign o_saturated  = r_out_sat;
    assign o_run_done   = r_out_done;

endmodule

>>> sv/isps_ctrl.sv
// ---------------------------------------------------------------------------
// isps_ctrl
// Controller: takes requests, walks the table for a query, waits for the
// pipeline to drain and hands the final sum to the result register.
// ---------------------------------------------------------------------------
module isps_ctrl
    import isps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    i_ready,
    input  logic    i_opcode,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FINAL = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] n_idx;

    assign i_ready = (r_state == S_IDLE);

    always_comb begin
        n_state          = r_state;
        n_idx            = r_idx;
        o_cmd            = '0;
        o_cmd.issue_idx  = r_idx[IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_valid) begin
                    if (i_opcode == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.take_query = 1'b1;
                        n_state = (i_status.count == '0) ? S_DRAIN : S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                n_idx       = r_idx + CNT_W'(1);
                if (n_idx == i_status.count) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.busy) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                // wait until the previous result has been taken
                if (!i_status.out_full) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

>>> sv/inverse_square_pair_sum_top.sv
// ---------------------------------------------------------------------------
// inverse_square_pair_sum_top
// Point table with inverse-square interaction sums against a local point.
// ---------------------------------------------------------------------------
// A load request stores one remote point; a load that is not a first item
// is dropped when the table is full. A query request walks the stored points
// one per cycle into a read/difference/square front end followed by a
// 49-stage pipelined divider, through the single memory read port of the
// table. The input is held off until the query has handed its sum on. The
// result sits in an output register, and the next request is taken while it
// waits; a query only stalls at its final step if that register is still
// full. The table needs no clearing after reset.
module inverse_square_pair_sum_top
    import isps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             i_ready,
    input  logic             i_opcode,
    input  logic [PT_W-1:0]  i_point,
    input  logic             i_first_item,
    input  logic             i_last_item,
    input  logic [ACC_W-1:0] i_acc_in,
    output logic             o_valid,
    input  logic             o_ready,
    output logic [ACC_W-1:0] o_result_sum,
    output logic             o_saturated,
    output logic             o_run_done
);

    t_cmd    cmd;
    t_status status;

    isps_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_ready  (i_ready),
        .i_opcode (i_opcode),
        .i_status (status),
        .o_cmd    (cmd)
    );

    isps_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_point      (i_point),
        .i_first_item (i_first_item),
        .i_last_item  (i_last_item),
        .i_acc_in     (i_acc_in),
        .o_valid      (o_valid),
        .o_ready      (o_ready),
        .o_result_sum (o_result_sum),
        .o_saturated  (o_saturated),
        .o_run_done   (o_run_done)
    );

endmodule

>>> sv/isps_checker.sv
// ---------------------------------------------------------------------------
// isps_checker
// Port-level checks for the inverse-square pair sum block.
// ---------------------------------------------------------------------------
module isps_checker
    import isps_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             i_ready,
    input logic             i_opcode,
    input logic             o_valid,
    input logic             o_ready,
    input logic [ACC_W-1:0] o_result_sum,
    input logic             o_saturated
);

    // result holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ready |=> o_valid && $stable(o_result_sum))
        else $error("result changed while stalled");

    // a clipped sum always reads as the maximum
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_result_sum == {ACC_W{1'b1}})
        else $error("saturated flag without maximum sum");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a load never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && (i_opcode == OP_LOAD) && !o_valid |=> !o_valid)
        else $error("result appeared after a load");

endmodule

bind inverse_square_pair_sum_top isps_checker u_isps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .i_ready      (i_ready),
    .i_opcode     (i_opcode),
    .o_valid      (o_valid),
    .o_ready      (o_ready),
    .o_result_sum (o_result_sum),
    .o_saturated  (o_saturated)
);

>>> verif/tb_inverse_square_pair_sum_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_inverse_square_pair_sum_top
// Loads point tables and runs inverse-square sum queries against them. Every
// accepted request goes through a local copy of the table that predicts
// sum, clip flag and run flag. Each result is checked in order against that
// prediction, with random idling on both channels and long output stalls.
// ---------------------------------------------------------------------------
module tb_inverse_square_pair_sum_top;
    import isps_pkg::*;

    localparam int               HALF_PERIOD = 6;
    localparam int               CYCLE_LIMIT = 3_000_000;
    localparam int               DRAIN_CYCLES = 400;
    localparam int               HOLD_LEN    = 1000;
    localparam int               HOLD_AT_A   = 20;
    localparam int               HOLD_AT_B   = 250;
    localparam int               NUM_ITEMS   = 1000;
    localparam logic [ACC_W-1:0] ACC_MAX     = '1;
    localparam logic [ACC_W-1:0] TERM_ONE    = 64'd1 << 48;

    typedef struct {
        logic             op;
        logic [PT_W-1:0]  point;
        logic             first;
        logic             last;
        logic [ACC_W-1:0] acc;
    } t_req;

    typedef struct {
        logic [ACC_W-1:0] sum;
        logic             sat;
        logic             done;
    } t_sum;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             i_ready;
    logic             i_opcode = OP_LOAD;
    logic [PT_W-1:0]  i_point = '0;
    logic             i_first_item = 1'b0;
    logic             i_last_item = 1'b0;
    logic [ACC_W-1:0] i_acc_in = '0;
    logic             o_valid;
    logic             o_ready = 1'b0;
    logic [ACC_W-1:0] o_result_sum;
    logic             o_saturated;
    logic             o_run_done;

    inverse_square_pair_sum_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_ready      (i_ready),
        .i_opcode     (i_opcode),
        .i_point      (i_point),
        .i_first_item (i_first_item),
        .i_last_item  (i_last_item),
        .i_acc_in     (i_acc_in),
        .o_valid      (o_valid),
        .o_ready      (o_ready),
        .o_result_sum (o_result_sum),
        .o_saturated  (o_saturated),
        .o_run_done   (o_run_done)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    t_req            pending_reqs[$];
    t_sum            expected_sums[$];
    logic [PT_W-1:0] remote_tbl[MAX_POINTS];
    int unsigned     tbl_count = 0;
    logic [PT_W-1:0] gen_pts[$];
    int              n_items = 0;
    int              idle_pct = 30;
    int              errors = 0;
    int              results_seen = 0;
    int              send_wait = 0;
    int              recv_wait = 0;
    int              hold_left = 0;
    int              cycle_count = 0;
    logic            in_fire = 1'b0;
    logic            out_fire = 1'b0;

    // ---------------------------------------------------------------- model
    function automatic logic [ACC_W-1:0] add_clip(input logic [ACC_W-1:0] a,
                                                  input logic [ACC_W-1:0] b,
                                                  inout logic clip);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[ACC_W]) begin
            clip = 1'b1;
            return ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

    task automatic take_request(input t_req r);
        logic [63:0]      d;
        logic [ACC_W-1:0] s;
        logic             clip;
        t_sum             e;
        if (r.op == OP_LOAD) begin
            if (r.first) tbl_count = 0;
            // full table drops the point
            if (tbl_count < MAX_POINTS) begin
                remote_tbl[tbl_count] = r.point;
                tbl_count++;
            end
        end else begin
            s    = '0;
            clip = 1'b0;
            for (int j = 0; j < tbl_count; j++) begin
                d = (r.point >= remote_tbl[j]) ? 64'(r.point - remote_tbl[j])
                                               : 64'(remote_tbl[j] - r.point);
                if (d != 0) s = add_clip(s, TERM_ONE / (d * d), clip);
            end
            e.sum  = add_clip(r.acc, s, clip);
            e.sat  = clip;
            e.done = r.last;
            expected_sums.push_back(e);
        end
    endtask

    // ------------------------------------------------------------ stimulus
    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(10, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [ACC_W-1:0] rand_acc();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return {$urandom, $urandom};
            5, 6:          return 64'($urandom_range(0, 1 << 20));
            7, 8:          return ACC_MAX - 64'($urandom_range(0, 1 << 20));
            default:       return ACC_MAX - ({32'd0, $urandom} << $urandom_range(0, 22));
        endcase
    endfunction

    // query and some load points often land near or on stored points to get large terms
    function automatic logic [PT_W-1:0] rand_point();
        logic [PT_W-1:0] base;
        if (gen_pts.size() == 0 || $urandom_range(0, 4) < 2) return PT_W'($urandom);
        base = gen_pts[$urandom_range(0, gen_pts.size() - 1)];
        if ($urandom_range(0, 2) == 0) return base;
        return base + PT_W'($urandom_range(0, 16)) - PT_W'(8);
    endfunction

    task automatic push_req(input logic op, input logic [PT_W-1:0] pt,
                            input logic first, input logic last,
                            input logic [ACC_W-1:0] acc);
        t_req r;
        r.op    = op;
        r.point = pt;
        r.first = first;
        r.last  = last;
        r.acc   = acc;
        pending_reqs.push_back(r);
        n_items++;
    endtask

    task automatic build_stimulus();
        int n;
        int m;
        int seq;
        logic [PT_W-1:0] p;
        // empty table, extremes, equal points, exact and clipped max
        push_req(OP_QUERY, 16'd1234, 1'b1, 1'b0, '0);
        push_req(OP_QUERY, 16'd0, 1'b0, 1'b1, ACC_MAX);
        push_req(OP_LOAD, 16'd0, 1'b1, 1'b1, ACC_MAX);
        push_req(OP_LOAD, 16'hffff, 1'b0, 1'b0, '0);
        push_req(OP_QUERY, 16'd0, 1'b0, 1'b0, '0);
        push_req(OP_QUERY, 16'hffff, 1'b0, 1'b0, ACC_MAX);
        push_req(OP_QUERY, 16'h8000, 1'b0, 1'b1, 64'd12345);
        push_req(OP_LOAD, 16'd100, 1'b1, 1'b0, '0);
        push_req(OP_QUERY, 16'd101, 1'b0, 1'b0, ACC_MAX - TERM_ONE);
        push_req(OP_QUERY, 16'd100, 1'b0, 1'b0, {$urandom, $urandom});
        push_req(OP_QUERY, 16'd99, 1'b0, 1'b0, ACC_MAX - TERM_ONE + 1);
        push_req(OP_LOAD, 16'd100, 1'b0, 1'b0, '0);
        push_req(OP_LOAD, 16'd102, 1'b0, 1'b1, '0);
        push_req(OP_QUERY, 16'd101, 1'b1, 1'b1, '0);

        seq = 0;
        while (n_items < NUM_ITEMS) begin
            if (seq % 30 != 3 && $urandom_range(0, 99) < 15) begin
                // noise: any field combination, loads may append or overflow
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    push_req(1'($urandom), PT_W'($urandom), 1'($urandom),
                             1'($urandom), rand_acc());
            end else begin
                // small tables, and now and then a full table plus a few dropped loads
                n = (seq % 30 == 3) ? $urandom_range(MAX_POINTS, MAX_POINTS + 4)
                                    : $urandom_range(1, 16);
                m = (seq % 30 == 3) ? $urandom_range(1, 3) : $urandom_range(1, 8);
                gen_pts.delete();
                for (int k = 0; k < n; k++) begin
                    p = ($urandom_range(0, 3) == 0 && gen_pts.size() > 0)
                        ? rand_point() : PT_W'($urandom);
                    gen_pts.push_back(p);
                    push_req(OP_LOAD, p, k == 0, k == n - 1, rand_acc());
                end
                for (int k = 0; k < m; k++)
                    push_req(OP_QUERY, rand_point(), 1'($urandom), k == m - 1,
                             rand_acc());
            end
            seq++;
        end
    endtask

    // --------------------------------------------------------------- driver
    always @(negedge i_clk) begin
        t_req r;
        if (i_rst_n && !(i_valid && !in_fire)) begin
            if (in_fire) send_wait = pick_gap(idle_pct);
            if (send_wait > 0) begin
                send_wait--;
                i_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                r = pending_reqs.pop_front();
                i_valid      <= 1'b1;
                i_opcode     <= r.op;
                i_point      <= r.point;
                i_first_item <= r.first;
                i_last_item  <= r.last;
                i_acc_in     <= r.acc;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------- receiver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            // long hold-off lets the block fill up and stall its input
            if (out_fire && (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B))
                hold_left = HOLD_LEN;
            else if (out_fire)
                recv_wait = pick_gap(idle_pct);
            else if (o_ready && $urandom_range(99) < idle_pct / 10)
                recv_wait = pick_gap(100);
            if (hold_left > 0) begin
                hold_left--;
                o_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                o_ready <= 1'b0;
            end else begin
                o_ready <= 1'b1;
            end
        end
    end

    // -------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        t_req r;
        t_sum e;
        in_fire  <= i_rst_n && i_valid && i_ready;
        out_fire <= i_rst_n && o_valid && o_ready;
        if (i_rst_n && i_valid && i_ready) begin
            r.op    = i_opcode;
            r.point = i_point;
            r.first = i_first_item;
            r.last  = i_last_item;
            r.acc   = i_acc_in;
            take_request(r);
        end
        if (i_rst_n && o_valid && o_ready) begin
            results_seen <= results_seen + 1;
            if (expected_sums.size() == 0) begin
                $display("%0t: unexpected result, sum %h saturated %b run_done %b",
                         $time, o_result_sum, o_saturated, o_run_done);
                errors++;
            end else begin
                e = expected_sums.pop_front();
                if (o_result_sum !== e.sum) begin
                    $display("%0t: result_sum expected %h actual %h",
                             $time, e.sum, o_result_sum);
                    errors++;
                end
                if (o_saturated !== e.sat) begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, e.sat, o_saturated);
                    errors++;
                end
                if (o_run_done !== e.done) begin
                    $display("%0t: run_done expected %b actual %b",
                             $time, e.done, o_run_done);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        build_stimulus();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_reqs.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_sums.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
